[rtl/core/u2u_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; used by the front, queue, back and top-level modules.

package u2u_pkg;

   localparam int UNIT_W      = 16;
   localparam int MAX_UNITS   = 4;
   localparam int COUNT_W     = 3;
   localparam int QUEUE_DEPTH = 2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IGNORE_HEADER   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVALID_TO_NULL = 1'd1;

   // all code units produced by one input byte
   typedef struct packed {
      logic [COUNT_W-1:0]                 count;
      logic [MAX_UNITS-1:0]               inv;
      logic [MAX_UNITS-1:0][UNIT_W-1:0]   unit;
   } u2u_bundle_type;

endpackage

[rtl/core/u2u_front.sv]
// Front end: config registers, byte decode state and per-byte unit bundles.
// Depends on u2u_pkg.

module u2u_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [u2u_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic                               csr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // byte_value
   input  logic                               req_tlast,   // end_of_stream
   input  logic                               queue_full,
   output logic                               push_valid,
   output u2u_pkg::u2u_bundle_type            push_bundle
);

   localparam logic [20:0] MAX_CODE    = 21'h10FFFF;
   localparam logic [20:0] BOM_CODE    = 21'h00FEFF;
   localparam logic [20:0] NC_LOW      = 21'h00FDD0;
   localparam logic [20:0] NC_HIGH     = 21'h00FDEF;
   localparam logic [20:0] SUR_LOW     = 21'h00D800;
   localparam logic [20:0] SUR_END     = 21'h00E000;
   localparam logic [20:0] PLANE1      = 21'h010000;
   localparam logic [15:0] REPLACEMENT = 16'hFFFD;

   logic [1:0]  need_ff, need_in;
   logic [1:0]  len_ff, len_in;
   logic [1:0]  ct_ff, ct_in;
   logic [20:0] acc_ff, acc_in;
   logic        header_ff, header_in;
   logic        ignore_header_ff, invalid_to_null_ff;

   logic        accept;
   logic        hs;
   logic        is_cont;
   logic [20:0] u;
   logic [20:0] v;
   logic [20:0] min_code;
   logic        nc, sur, pair, bad, drop;
   logic [15:0] rep;
   logic [1:0]  pre, mid_n, post;
   logic [15:0] mid0, mid1;
   logic        mid0_inv;
   logic        do_lead;
   logic [u2u_pkg::COUNT_W-1:0] pre3, mid_end3;
   u2u_pkg::u2u_bundle_type     bundle;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   assign hs      = header_ff | ignore_header_ff;
   assign is_cont = (req_tdata[7:6] == 2'b10);
   assign rep     = invalid_to_null_ff ? 16'h0000 : REPLACEMENT;
   assign u       = {acc_ff[14:0], req_tdata[5:0]};
   assign v       = u - PLANE1;

   always_comb begin
      unique case (len_ff)
         2'd1:    min_code = 21'h000080;
         2'd2:    min_code = 21'h000800;
         2'd3:    min_code = PLANE1;
         default: min_code = 21'h000000;
      endcase
   end

   // checks on a completed code point
   assign nc   = (u >= NC_LOW) && ((u <= NC_HIGH) || (u[15:1] == 15'h7FFF));
   assign sur  = (u >= SUR_LOW) && (u < SUR_END);
   assign pair = !nc && (u >= PLANE1) && (u <= MAX_CODE);
   assign bad  = (u < min_code) || sur || nc || (u > MAX_CODE);
   assign drop = !hs && (u == BOM_CODE);

   always_comb begin
      need_in   = need_ff;
      len_in    = len_ff;
      acc_in    = acc_ff;
      ct_in     = ct_ff;
      header_in = hs;
      pre       = 2'd0;
      mid_n     = 2'd0;
      mid0      = 16'h0000;
      mid0_inv  = 1'b0;
      mid1      = 16'h0000;
      do_lead   = 1'b0;

      if (need_ff != 2'd0) begin
         if (is_cont) begin
            if (need_ff == 2'd1) begin
               need_in   = 2'd0;
               len_in    = 2'd0;
               acc_in    = 21'd0;
               ct_in     = 2'd0;
               header_in = 1'b1;
               priority if (drop) begin
                  mid_n = 2'd0;
               end else if (pair) begin
                  mid_n = 2'd2;
                  mid0  = {6'b110110, v[19:10]};
                  mid1  = {6'b110111, v[9:0]};
               end else if (bad) begin
                  mid_n    = 2'd1;
                  mid0     = rep;
                  mid0_inv = 1'b1;
               end else begin
                  mid_n = 2'd1;
                  mid0  = u[15:0];
               end
            end else begin
               need_in = need_ff - 2'd1;
               acc_in  = u;
               ct_in   = ct_ff + 2'd1;
            end
         end else begin
            // broken sequence: lead plus taken continuations, then re-decode
            pre       = ct_ff + 2'd1;
            need_in   = 2'd0;
            header_in = 1'b1;
            do_lead   = 1'b1;
         end
      end else begin
         do_lead = 1'b1;
      end

      if (do_lead) begin
         ct_in = 2'd0;
         priority if (!req_tdata[7]) begin
            mid_n     = 2'd1;
            mid0      = {8'h00, req_tdata};
            header_in = 1'b1;
         end else if (req_tdata[7:5] == 3'b110) begin
            acc_in    = {16'd0, req_tdata[4:0]};
            need_in   = 2'd1;
            len_in    = 2'd1;
            header_in = 1'b1;
         end else if (req_tdata[7:4] == 4'b1110) begin
            acc_in  = {17'd0, req_tdata[3:0]};
            need_in = 2'd2;
            len_in  = 2'd2;
         end else if (req_tdata[7:3] == 5'b11110) begin
            acc_in    = {18'd0, req_tdata[2:0]};
            need_in   = 2'd3;
            len_in    = 2'd3;
            header_in = 1'b1;
         end else begin
            mid_n     = 2'd1;
            mid0      = rep;
            mid0_inv  = 1'b1;
            header_in = 1'b1;
         end
      end

      post = 2'd0;
      if (req_tlast) begin
         if (need_in != 2'd0) begin
            post = ct_in + 2'd1;
         end
         need_in   = 2'd0;
         len_in    = 2'd0;
         acc_in    = 21'd0;
         ct_in     = 2'd0;
         header_in = 1'b0;
      end
   end

   // lay out: replacements before, decoded units, replacements after
   assign pre3     = {1'b0, pre};
   assign mid_end3 = {1'b0, pre} + {1'b0, mid_n};

   always_comb begin
      bundle.count = {1'b0, pre} + {1'b0, mid_n} + {1'b0, post};
      for (int j = 0; j < u2u_pkg::MAX_UNITS; j++) begin
         if (u2u_pkg::COUNT_W'(j) < pre3) begin
            bundle.unit[j] = rep;
            bundle.inv[j]  = 1'b1;
         end else if (u2u_pkg::COUNT_W'(j) < mid_end3) begin
            bundle.unit[j] = (u2u_pkg::COUNT_W'(j) == pre3) ? mid0 : mid1;
            bundle.inv[j]  = (u2u_pkg::COUNT_W'(j) == pre3) ? mid0_inv : 1'b0;
         end else begin
            bundle.unit[j] = rep;
            bundle.inv[j]  = 1'b1;
         end
      end
   end

   assign push_valid  = accept && (bundle.count != '0);
   assign push_bundle = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff            <= 2'd0;
         len_ff             <= 2'd0;
         acc_ff             <= 21'd0;
         ct_ff              <= 2'd0;
         header_ff          <= 1'b0;
         ignore_header_ff   <= 1'b0;
         invalid_to_null_ff <= 1'b0;
      end else begin
         if (accept) begin
            need_ff   <= need_in;
            len_ff    <= len_in;
            acc_ff    <= acc_in;
            ct_ff     <= ct_in;
            header_ff <= header_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               u2u_pkg::CSR_IGNORE_HEADER:   ignore_header_ff   <= csr_data;
               u2u_pkg::CSR_INVALID_TO_NULL: invalid_to_null_ff <= csr_data;
            endcase
         end
      end
   end

`ifndef SYNTH
   a_ct_idle: assert property (@(posedge clock) disable iff (reset)
      (need_ff == 2'd0) |-> (ct_ff == 2'd0))
      else $error("continuation count set with no sequence open");
   a_ct_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, need_ff} + {1'b0, ct_ff}) <= 3'd3)
      else $error("sequence length exceeded");
`endif

endmodule

[rtl/core/u2u_queue.sv]
// Small FIFO of per-byte unit bundles between the decoder front and back.
// Depends on u2u_pkg.

module u2u_queue #(
   parameter int DEPTH = u2u_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  u2u_pkg::u2u_bundle_type  push_bundle,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output u2u_pkg::u2u_bundle_type  head_bundle
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   u2u_pkg::u2u_bundle_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full        = (count_ff == CNT_W'(DEPTH));
   assign head_valid  = (count_ff != '0);
   assign head_bundle = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_bundle;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("bundle written into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("bundle popped from an empty queue");
`endif

endmodule

[rtl/core/u2u_back.sv]
// Back end: serializes queued bundles into single code-unit words with an
// output register. Depends on u2u_pkg.

module u2u_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  u2u_pkg::u2u_bundle_type  head_bundle,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,   // code_unit
   output logic                     rsp_tuser,   // is_invalid
   output logic                     rsp_tlast    // last_in_run
);

   logic [1:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_unit_ff;
   logic        out_inv_ff;
   logic        out_last_ff;
   logic        load;
   logic        last;

   assign load = head_valid && (!out_valid_ff || rsp_tready);
   assign last = ({1'b0, idx_ff} == (head_bundle.count - 3'd1));
   assign pop  = load && last;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         idx_in       = last ? 2'd0 : idx_ff + 2'd1;
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_unit_ff <= head_bundle.unit[idx_ff];
         out_inv_ff  <= head_bundle.inv[idx_ff];
         out_last_ff <= last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_unit_ff;
   assign rsp_tuser  = out_inv_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTH
   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ({1'b0, idx_ff} < head_bundle.count))
      else $error("unit index past end of bundle");
   a_mid_bundle: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> head_valid)
      else $error("bundle left the queue before all words were sent");
`endif

endmodule

[rtl/core/utf8_to_utf16_decoder_top.sv]
// UTF-8 to UTF-16 decoder, top level.
// Depends on u2u_pkg, u2u_front, u2u_queue and u2u_back.

// Accepts one UTF-8 byte per cycle on req_ and sends UTF-16 code units on
// rsp_, one word per cycle while rsp_tready is high. A byte gives zero to
// four units; the units caused by one byte leave as one run with rsp_tlast
// on its final word, and rsp_tuser flags replacement units. The front
// decodes a byte in the cycle it is accepted and writes its units as one
// bundle into a two-entry queue; the back sends them one word at a time.
// Sustained rate is one byte per cycle while bytes give at most one unit
// each and rsp_tready stays high; a byte giving more units holds the output
// until all are sent. Units pass the queue and the output register before
// rsp_. req_tready falls only while the queue is full. The csr_ port is
// always ready; write it only while the block is idle.

module utf8_to_utf16_decoder_top #(
   parameter int QUEUE_DEPTH = u2u_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [u2u_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic                             csr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] byte_value
   input  logic                             req_tlast,   // end_of_stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // [15:0] code_unit
   output logic                             rsp_tuser,   // [0] is_invalid
   output logic                             rsp_tlast    // last_in_run
);

   logic                    queue_full;
   logic                    push_valid;
   u2u_pkg::u2u_bundle_type push_bundle;
   logic                    pop;
   logic                    head_valid;
   u2u_pkg::u2u_bundle_type head_bundle;

   u2u_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_bundle (push_bundle)
   );

   u2u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .full        (queue_full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_bundle (head_bundle)
   );

   u2u_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_bundle (head_bundle),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
